FILE: rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frame sequence checker.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Width of the internal event counters (8 .. 64); results carry 32 bits.
  localparam int unsigned CountW = 32;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned TagW      = 32;
  localparam int unsigned CountOutW = 32;

  // running + display_time + render_wanted + thread_tag + left_ok + right_ok
  localparam int unsigned InFieldsW  = 1 + TimeW + 1 + TagW + 1 + 1;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  // status + render_now + three counters
  localparam int unsigned OutFieldsW = StatusW + 1 + 3 * CountOutW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_SET_SESSION = 3'd0,
    CMD_WAITED      = 3'd1,
    CMD_VIEWS       = 3'd2,
    CMD_BEGUN       = 3'd3,
    CMD_SUBMITTED   = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK             = 3'd0,
    ST_NOT_RUNNING    = 3'd1,
    ST_ALREADY_WAITED = 3'd2,
    ST_OUT_OF_ORDER   = 3'd3,
    ST_NO_VIEWS       = 3'd4,
    ST_WRONG_THREAD   = 3'd5
  } status_e;

  typedef logic [CountW-1:0] count_t;

endpackage

FILE: rtl/frame_sequence_checker.sv
// ----------------------------------------------------------------------------
// frame_sequence_checker
// Tracks the frame loop (session, wait, views, begin, submit), answers every
// event with a status code and keeps done / skipped / error counters.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+-------
//  s_axis  | in  | running, display_time, render_wanted,      | cmd
//          |     | thread_tag, left_ok, right_ok, zero pad    |
//  m_axis  | out | status, render_now, frames_done,           | -
//          |     | frames_skipped, error_count, zero pad      |
//
//  - One event per clock while m_axis is not stalled: the frame state,
//    the counters and the output register all update at the transfer edge.
//  - The next-state logic (one 64-bit compare, one 32-bit compare, one
//    counter increment) sits between the frame state and the output
//    register.
//  - s_axis_tready is high while the output register is empty or being
//    drained, so a stalled m_axis holds exactly one result and blocks input.
//  - rst_ni clears the frame state, the session flag, all counters and the
//    output valid.
//
module frame_sequence_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] running, [64:1] display_time, [65] render_wanted,
  // [97:66] thread_tag, [98] left_ok, [99] right_ok, [103:100] zero
  input  logic [fsc_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] cmd
  input  logic [fsc_pkg::CmdW-1:0]      s_axis_tuser,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [3] render_now, [35:4] frames_done,
  // [67:36] frames_skipped, [99:68] error_count, [103:100] zero
  output logic [fsc_pkg::OutDataW-1:0]  m_axis_tdata
);

  import fsc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAITED = 2'd1,
    PH_BEGUN  = 2'd2
  } phase_e;

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  cmd_e                 in_cmd;
  logic                 in_running;
  logic [TimeW-1:0]     in_time;
  logic                 in_want;
  logic [TagW-1:0]      in_tag;
  logic                 in_left;
  logic                 in_right;

  assign in_cmd     = cmd_e'(s_axis_tuser);
  assign in_running = s_axis_tdata[0];
  assign in_time    = s_axis_tdata[TimeW:1];
  assign in_want    = s_axis_tdata[TimeW+1];
  assign in_tag     = s_axis_tdata[TimeW+TagW+1:TimeW+2];
  assign in_left    = s_axis_tdata[TimeW+TagW+2];
  assign in_right   = s_axis_tdata[TimeW+TagW+3];

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  phase_e           phase_q, phase_d;
  logic             session_q, session_d;
  logic             want_q, want_d;
  logic [TimeW-1:0] pred_time_q, pred_time_d;
  logic [TagW-1:0]  waiter_q, waiter_d;
  logic             left_q, left_d;
  logic             right_q, right_d;
  count_t           done_q, done_d;
  count_t           skip_q, skip_d;
  count_t           fail_q, fail_d;

  status_e          status;
  logic             render_now;

  logic             accept;
  logic             m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next frame state for the event on the slave side.
  always_comb begin
    phase_d     = phase_q;
    session_d   = session_q;
    want_d      = want_q;
    pred_time_d = pred_time_q;
    waiter_d    = waiter_q;
    left_d      = left_q;
    right_d     = right_q;
    done_d      = done_q;
    skip_d      = skip_q;
    status      = ST_OK;

    case (in_cmd)
      CMD_SET_SESSION: begin
        // session drop wipes the frame, counters survive
        if (session_q && !in_running) begin
          phase_d     = PH_IDLE;
          want_d      = 1'b0;
          pred_time_d = '0;
          waiter_d    = '0;
          left_d      = 1'b0;
          right_d     = 1'b0;
        end
        session_d = in_running;
      end
      CMD_WAITED: begin
        if (!session_q) begin
          status = ST_NOT_RUNNING;
        end else if (phase_q == PH_WAITED) begin
          status = ST_ALREADY_WAITED;
        end else if (phase_q != PH_IDLE) begin
          status = ST_OUT_OF_ORDER;
        end else begin
          phase_d     = PH_WAITED;
          pred_time_d = in_time;
          want_d      = in_want;
          waiter_d    = in_tag;
          left_d      = 1'b0;
          right_d     = 1'b0;
        end
      end
      CMD_VIEWS: begin
        // views only count for the frame whose time was predicted
        if (phase_q != PH_WAITED || in_time != pred_time_q) begin
          status = ST_OUT_OF_ORDER;
        end else begin
          left_d  = in_left;
          right_d = in_right;
        end
      end
      CMD_BEGUN: begin
        if (phase_q != PH_WAITED) begin
          status = ST_OUT_OF_ORDER;
        end else if (want_q && !(left_q && right_q)) begin
          status = ST_NO_VIEWS;
        end else begin
          phase_d = PH_BEGUN;
        end
      end
      CMD_SUBMITTED: begin
        if (phase_q != PH_BEGUN) begin
          status = ST_OUT_OF_ORDER;
        end else if (in_tag == waiter_q) begin
          // frame is still closed out, just not counted
          phase_d = PH_IDLE;
          status  = ST_WRONG_THREAD;
        end else begin
          if (session_q && want_q && left_q && right_q) begin
            done_d = done_q + count_t'(1);
          end else begin
            skip_d = skip_q + count_t'(1);
          end
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // unused event codes: no change, status ok
      end
    endcase

    fail_d     = (status != ST_OK) ? fail_q + count_t'(1) : fail_q;
    render_now = session_d && want_d && left_d && right_d;
  end

  // Result packing; counters are presented as 32-bit fields.
  always_comb begin
    m_data_d = '0;
    m_data_d[StatusW-1:0]                      = status;
    m_data_d[StatusW]                          = render_now;
    m_data_d[StatusW+CountOutW:StatusW+1]      = CountOutW'(done_d);
    m_data_d[StatusW+2*CountOutW:StatusW+CountOutW+1] = CountOutW'(skip_d);
    m_data_d[StatusW+3*CountOutW:StatusW+2*CountOutW+1] = CountOutW'(fail_d);
  end

  always_comb begin
    if (accept) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      session_q   <= 1'b0;
      want_q      <= 1'b0;
      pred_time_q <= '0;
      waiter_q    <= '0;
      left_q      <= 1'b0;
      right_q     <= 1'b0;
      done_q      <= '0;
      skip_q      <= '0;
      fail_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (accept) begin
        phase_q     <= phase_d;
        session_q   <= session_d;
        want_q      <= want_d;
        pred_time_q <= pred_time_d;
        waiter_q    <= waiter_d;
        left_q      <= left_d;
        right_q     <= right_d;
        done_q      <= done_d;
        skip_q      <= skip_d;
        fail_q      <= fail_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // an open frame implies a live session
  a_frame_needs_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> session_q)
    else $error("frame open without session");

  // with no session the view bits and render request are clear
  a_no_session_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !session_q |-> (!left_q && !right_q && !want_q))
    else $error("frame state left over after session drop");

  // counters move only on a transfer
  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(done_q) && $stable(skip_q) && $stable(fail_q)))
    else $error("counter changed without a transfer");

  // a good submit counts exactly one frame
  a_submit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd == CMD_SUBMITTED && phase_q == PH_BEGUN && in_tag != waiter_q)
    |=> (count_t'(done_q + skip_q) == count_t'($past(done_q + skip_q) + count_t'(1))))
    else $error("submit did not count one frame");

  // any submit in begun phase closes the frame
  a_submit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd == CMD_SUBMITTED && phase_q == PH_BEGUN) |=> (phase_q == PH_IDLE))
    else $error("frame not closed after submit");
`endif

endmodule
